### rtl/three_level_page_table_macros.svh
// Assertion macros used by the page table RTL.
`ifndef THREE_LEVEL_PAGE_TABLE_MACROS_SVH
`define THREE_LEVEL_PAGE_TABLE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PTL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define PTL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ptl_pkg.sv
// Constants, types and helper functions of the three-level page table.
package ptl_pkg;

  // Sizing of the table.
  localparam int MAX_PAGE_BITS = 12;
  localparam int MID_BLOCKS    = 16;
  localparam int LEAF_BLOCKS   = 64;
  localparam int FRAME_BITS    = 16;

  // Fixed field widths of the ports.
  localparam int CMD_W       = 2;
  localparam int VPAGE_W     = 12;
  localparam int FRAME_W     = 16;
  localparam int STATUS_W    = 2;
  localparam int PB_W        = 4;
  localparam int MID_USED_W  = 5;
  localparam int LEAF_USED_W = 7;

  localparam int PB_MIN   = 3;
  localparam int PB_RESET = (12 > MAX_PAGE_BITS) ? MAX_PAGE_BITS : 12;

  // Geometry of the three levels.
  localparam int MID_SLOT_BITS  = MAX_PAGE_BITS / 3;
  localparam int TOP_SLOTS      = 1 << MID_SLOT_BITS;
  localparam int MID_SLOTS      = 1 << MID_SLOT_BITS;
  localparam int LEAF_SLOT_BITS = (MAX_PAGE_BITS + 1) / 3 + 1;
  localparam int LEAF_SLOTS     = 1 << LEAF_SLOT_BITS;

  // Block pointers and pool counters.
  localparam int MID_IDX_W  = (MID_BLOCKS > 1) ? $clog2(MID_BLOCKS) : 1;
  localparam int LEAF_IDX_W = (LEAF_BLOCKS > 1) ? $clog2(LEAF_BLOCKS) : 1;
  localparam int MID_CNT_W  = $clog2(MID_BLOCKS + 1);
  localparam int LEAF_CNT_W = $clog2(LEAF_BLOCKS + 1);

  // Walk memory: middle-level pointers first, then one valid row per leaf block.
  localparam int LEAF_BASE  = MID_BLOCKS * MID_SLOTS;
  localparam int WALK_DEPTH = LEAF_BASE + LEAF_BLOCKS;
  localparam int WALK_W     = (LEAF_SLOTS > LEAF_IDX_W) ? LEAF_SLOTS : LEAF_IDX_W;
  localparam int WALK_AW    = $clog2(WALK_DEPTH);

  // Frame memory: one entry per leaf slot.
  localparam int FRAME_DEPTH = LEAF_BLOCKS * LEAF_SLOTS;
  localparam int FRAME_AW    = $clog2(FRAME_DEPTH);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP     = 2'd0,
    CMD_INSERT     = 2'd1,
    CMD_INVALIDATE = 2'd2,
    CMD_NOP        = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_RANGE     = 2'd1,
    STATUS_EXHAUSTED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TOP,
    ST_MID,
    ST_LEAF
  } walk_state_e;

  // Floor of pb / 3 as a multiply by 11 and a shift; exact for all 4-bit inputs.
  function automatic logic [PB_W-1:0] pb_div3(input logic [PB_W-1:0] pb);
    logic [PB_W+3:0] prod;
    prod = (PB_W + 4)'(pb) * (PB_W + 4)'(11);
    return PB_W'(prod >> 5);
  endfunction

  // Clamp a written page bit count into the supported range.
  function automatic logic [PB_W-1:0] pb_saturate(input logic [PB_W-1:0] v);
    logic [PB_W-1:0] r;
    r = v;
    if (v < PB_W'(PB_MIN)) begin
      r = PB_W'(PB_MIN);
    end else if (int'(v) > MAX_PAGE_BITS) begin
      r = PB_W'(MAX_PAGE_BITS);
    end
    return r;
  endfunction

endpackage

### rtl/ptl_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module ptl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds its value while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/three_level_page_table.sv
// Three-level radix page table: lookup, insert and invalidate of single pages.
//
// The block takes one item at a time and walks the table through its levels.
// Acceptance registers the item; a full walk then passes ST_TOP, which
// consults the top directory (held in flip-flops along with the middle-level
// valid rows) and starts the walk memory read of the middle-level pointer,
// ST_MID, which starts the leaf valid row and frame read, and ST_LEAF, which
// registers the result. A no-op or an out-of-range page finishes in ST_TOP,
// and a walk that ends at an absent middle entry, or an insert that finds its
// pool exhausted, in ST_MID. A state that finishes an item waits there while
// the output register still holds an untaken result. The next item is
// accepted in the cycle after its predecessor's result has been registered,
// while that result may still wait for the consumer. Since only one item is
// in the walk at a time, every write back lands before the next item's first
// read, and no forwarding is needed.
// Reset, or a write of the page width register, empties the table at once:
// the top valid bits and both pool counters are cleared, and no clearing pass
// is run, because every valid row is rewritten in full when its block is
// allocated. Configuration must only be written while the block is idle.
`include "three_level_page_table_macros.svh"

module three_level_page_table import ptl_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [PB_W-1:0]        cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [CMD_W-1:0]       cmd_i,
  input  logic [VPAGE_W-1:0]     virtual_page_i,
  input  logic [FRAME_W-1:0]     frame_in_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   hit_o,
  output logic [FRAME_W-1:0]     frame_out_o,
  output logic [STATUS_W-1:0]    status_o,
  output logic [MID_USED_W-1:0]  second_level_used_o,
  output logic [LEAF_USED_W-1:0] third_level_used_o
);

  // Control state.
  walk_state_e            state_q, state_d;
  logic [PB_W-1:0]        pb_q;
  logic [TOP_SLOTS-1:0]   top_valid_q;
  logic [MID_CNT_W-1:0]   mid_cnt_q;
  logic [LEAF_CNT_W-1:0]  leaf_cnt_q;
  logic                   out_valid_q;

  // Item and walk payload.
  cmd_e                   cmd_q;
  logic [VPAGE_W-1:0]     vp_q;
  logic [FRAME_BITS-1:0]  frm_q;
  logic [MID_IDX_W-1:0]   top_ptr_q [TOP_SLOTS];
  logic [MID_SLOTS-1:0]   mid_vmap_q [MID_BLOCKS];
  logic [LEAF_IDX_W-1:0]  leaf_blk_q, leaf_blk_d;
  logic                   alloc_q, alloc_d;

  // Result register.
  logic                   hit_q;
  logic [FRAME_W-1:0]     fout_q;
  status_e                status_q;
  logic [MID_USED_W-1:0]  mid_used_q;
  logic [LEAF_USED_W-1:0] leaf_used_q;

  // Index decode.
  logic [PB_W-1:0]           b1, b3;
  logic                      in_range;
  logic [MID_SLOT_BITS-1:0]  i1, i2;
  logic [LEAF_SLOT_BITS-1:0] i3;
  logic                      top_v, mid_v;
  logic [MID_IDX_W-1:0]      mid_blk, mid_blk_eff;
  logic [MID_SLOTS-1:0]      mid_row, mid_bit;
  logic [LEAF_SLOTS-1:0]     leaf_row, leaf_bit;
  logic [LEAF_IDX_W-1:0]     walk_ptr, new_blk;
  logic                      need_mid, need_leaf, exhausted;

  // Handshake and sequencing.
  logic                   accept, out_free, done;
  logic                   mid_alloc, leaf_alloc;
  logic                   res_hit;
  logic [FRAME_W-1:0]     res_frame;
  status_e                res_status;

  // Memory ports.
  logic                   walk_we, walk_re;
  logic [WALK_AW-1:0]     walk_waddr, walk_raddr;
  logic [WALK_W-1:0]      walk_wdata, walk_rdata;
  logic                   frame_we, frame_re;
  logic [FRAME_AW-1:0]    frame_waddr, frame_raddr;
  logic [FRAME_BITS-1:0]  frame_rdata;

  // The walk memory holds middle-level leaf pointers and the leaf valid rows.
  ptl_ram #(
    .WIDTH (WALK_W),
    .DEPTH (WALK_DEPTH)
  ) u_walk_ram (
    .clk_i   (clk_i),
    .we_i    (walk_we),
    .waddr_i (walk_waddr),
    .wdata_i (walk_wdata),
    .re_i    (walk_re),
    .raddr_i (walk_raddr),
    .rdata_o (walk_rdata)
  );

  // The frame memory holds one frame per leaf slot.
  ptl_ram #(
    .WIDTH (FRAME_BITS),
    .DEPTH (FRAME_DEPTH)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (frame_we),
    .waddr_i (frame_waddr),
    .wdata_i (frm_q),
    .re_i    (frame_re),
    .raddr_i (frame_raddr),
    .rdata_o (frame_rdata)
  );

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // Split of the page number: floor(pb/3) bits for each of the upper two
  // levels, the remaining bits for the leaf.
  assign b1       = pb_div3(pb_q);
  assign b3       = pb_q - (b1 << 1);
  assign in_range = (vp_q >> pb_q) == '0;
  assign i1       = MID_SLOT_BITS'(vp_q >> (pb_q - b1));
  assign i2       = MID_SLOT_BITS'((vp_q >> b3) & ~({VPAGE_W{1'b1}} << b1));
  assign i3       = LEAF_SLOT_BITS'(vp_q & ~({VPAGE_W{1'b1}} << b3));

  assign top_v    = top_valid_q[i1];
  assign mid_blk  = top_ptr_q[i1];
  assign mid_row  = mid_vmap_q[mid_blk];
  assign mid_bit  = {{(MID_SLOTS-1){1'b0}}, 1'b1} << i2;
  assign mid_v    = top_v && mid_row[i2];
  assign leaf_bit = {{(LEAF_SLOTS-1){1'b0}}, 1'b1} << i3;
  assign leaf_row = walk_rdata[LEAF_SLOTS-1:0];
  assign walk_ptr = walk_rdata[LEAF_IDX_W-1:0];

  // An insert may need a fresh middle block, a fresh leaf block, or both.
  assign need_mid  = !top_v;
  assign need_leaf = !mid_v;
  assign exhausted = (need_mid && (mid_cnt_q >= MID_CNT_W'(MID_BLOCKS))) ||
                     (need_leaf && (leaf_cnt_q >= LEAF_CNT_W'(LEAF_BLOCKS)));
  assign new_blk     = need_leaf ? LEAF_IDX_W'(leaf_cnt_q) : walk_ptr;
  assign mid_blk_eff = mid_alloc ? MID_IDX_W'(mid_cnt_q) : mid_blk;

  always_comb begin
    state_d     = state_q;
    leaf_blk_d  = leaf_blk_q;
    alloc_d     = alloc_q;
    done        = 1'b0;
    res_hit     = 1'b0;
    res_frame   = '0;
    res_status  = STATUS_OK;
    mid_alloc   = 1'b0;
    leaf_alloc  = 1'b0;
    walk_we     = 1'b0;
    walk_re     = 1'b0;
    walk_waddr  = '0;
    walk_raddr  = '0;
    walk_wdata  = '0;
    frame_we    = 1'b0;
    frame_re    = 1'b0;
    frame_waddr = '0;
    frame_raddr = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_TOP;
        end
      end
      ST_TOP: begin
        if (cmd_q == CMD_NOP || !in_range) begin
          if (out_free) begin
            done       = 1'b1;
            res_status = (cmd_q == CMD_NOP) ? STATUS_OK : STATUS_RANGE;
            state_d    = ST_IDLE;
          end
        end else begin
          // The pointer read is harmless when the top entry is invalid.
          walk_re    = 1'b1;
          walk_raddr = WALK_AW'({mid_blk, i2});
          state_d    = ST_MID;
        end
      end
      ST_MID: begin
        if (cmd_q == CMD_INSERT) begin
          if (exhausted) begin
            if (out_free) begin
              done       = 1'b1;
              res_status = STATUS_EXHAUSTED;
              state_d    = ST_IDLE;
            end
          end else begin
            mid_alloc   = need_mid;
            leaf_alloc  = need_leaf;
            leaf_blk_d  = new_blk;
            alloc_d     = need_leaf;
            frame_we    = 1'b1;
            frame_waddr = FRAME_AW'({new_blk, i3});
            if (need_leaf) begin
              walk_we    = 1'b1;
              walk_waddr = WALK_AW'({mid_blk_eff, i2});
              walk_wdata = WALK_W'(new_blk);
            end else begin
              walk_re    = 1'b1;
              walk_raddr = WALK_AW'(LEAF_BASE) + WALK_AW'(walk_ptr);
            end
            state_d = ST_LEAF;
          end
        end else if (!mid_v) begin
          if (out_free) begin
            done    = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          leaf_blk_d  = walk_ptr;
          walk_re     = 1'b1;
          walk_raddr  = WALK_AW'(LEAF_BASE) + WALK_AW'(walk_ptr);
          frame_re    = 1'b1;
          frame_raddr = FRAME_AW'({walk_ptr, i3});
          state_d     = ST_LEAF;
        end
      end
      ST_LEAF: begin
        if (out_free) begin
          done       = 1'b1;
          walk_waddr = WALK_AW'(LEAF_BASE) + WALK_AW'(leaf_blk_q);
          case (cmd_q)
            CMD_LOOKUP: begin
              res_hit   = leaf_row[i3];
              res_frame = leaf_row[i3] ? FRAME_W'(frame_rdata) : '0;
            end
            CMD_INSERT: begin
              // A fresh leaf block starts with only this slot valid.
              walk_we    = 1'b1;
              walk_wdata = WALK_W'(alloc_q ? leaf_bit : (leaf_row | leaf_bit));
            end
            CMD_INVALIDATE: begin
              walk_we    = 1'b1;
              walk_wdata = WALK_W'(leaf_row & ~leaf_bit);
            end
            default: begin
            end
          endcase
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pb_q        <= PB_W'(PB_RESET);
      top_valid_q <= '0;
      mid_cnt_q   <= '0;
      leaf_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        pb_q        <= pb_saturate(cfg_wdata_i);
        top_valid_q <= '0;
        mid_cnt_q   <= '0;
        leaf_cnt_q  <= '0;
      end else begin
        if (mid_alloc) begin
          top_valid_q[i1] <= 1'b1;
          mid_cnt_q       <= mid_cnt_q + MID_CNT_W'(1);
        end
        if (leaf_alloc) begin
          leaf_cnt_q <= leaf_cnt_q + LEAF_CNT_W'(1);
        end
      end
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_e'(cmd_i);
      vp_q  <= virtual_page_i;
      frm_q <= FRAME_BITS'(frame_in_i);
    end
    leaf_blk_q <= leaf_blk_d;
    alloc_q    <= alloc_d;
    // A fresh middle block starts with only this slot valid.
    if (mid_alloc) begin
      top_ptr_q[i1]                      <= MID_IDX_W'(mid_cnt_q);
      mid_vmap_q[MID_IDX_W'(mid_cnt_q)] <= mid_bit;
    end else if (leaf_alloc) begin
      mid_vmap_q[mid_blk] <= mid_row | mid_bit;
    end
    // Usage counts are captured after the item's own allocations.
    if (done) begin
      hit_q       <= res_hit;
      fout_q      <= res_frame;
      status_q    <= res_status;
      mid_used_q  <= MID_USED_W'(mid_cnt_q);
      leaf_used_q <= LEAF_USED_W'(leaf_cnt_q);
    end
  end

  assign in_stall_o          = (state_q != ST_IDLE);
  assign out_valid_o         = out_valid_q;
  assign hit_o               = hit_q;
  assign frame_out_o         = fout_q;
  assign status_o            = status_q;
  assign second_level_used_o = mid_used_q;
  assign third_level_used_o  = leaf_used_q;

  // Every allocated middle block is owned by exactly one valid top entry.
  `PTL_ASSERT_NOW(a_top_matches_pool, 1'b1, $countones(top_valid_q) == int'(mid_cnt_q),
    "top valid count differs from middle pool count")
  // A leaf pointer followed at the leaf level always names an allocated block.
  `PTL_ASSERT_NOW(a_leaf_ptr_allocated, state_q == ST_LEAF,
    LEAF_CNT_W'(leaf_blk_q) < leaf_cnt_q, "leaf walk uses an unallocated block")
  // The leaf pool never grows past its size.
  `PTL_ASSERT_NOW(a_leaf_pool_bound, 1'b1, leaf_cnt_q <= LEAF_CNT_W'(LEAF_BLOCKS),
    "leaf pool count overflow")
  // An accepted item always starts its walk at the top directory.
  `PTL_ASSERT_NEXT(a_accept_starts_walk, accept, state_q == ST_TOP,
    "accepted item did not start a walk")

endmodule

### tb/sv/three_level_page_table_test.sv
// Self-checking testbench of the three-level page table: directed and random items.
module three_level_page_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ptl_pkg::*;

  // One translation result as the block reports it.
  typedef struct {
    logic                   hit;
    logic [FRAME_W-1:0]     frame;
    status_e                status;
    logic [MID_USED_W-1:0]  mid_used;
    logic [LEAF_USED_W-1:0] leaf_used;
  } walk_result_t;

  // The scoreboard keeps its own copy of the radix table. It walks that copy for
  // every accepted item and queues the result that the block should return.
  class page_walk_scoreboard;
    int unsigned        page_width;
    bit                 top_valid  [TOP_SLOTS];
    int unsigned        top_block  [TOP_SLOTS];
    bit                 mid_valid  [MID_BLOCKS*MID_SLOTS];
    int unsigned        mid_block  [MID_BLOCKS*MID_SLOTS];
    bit                 leaf_valid [LEAF_BLOCKS*LEAF_SLOTS];
    logic [FRAME_W-1:0] leaf_frame [LEAF_BLOCKS*LEAF_SLOTS];
    int unsigned        mids_taken;
    int unsigned        leaves_taken;
    walk_result_t       expected_walks [$];
    int unsigned        mismatches;

    function new();
      page_width = PB_RESET;
      mismatches = 0;
      empty_table();
    endfunction

    function void empty_table();
      foreach (top_valid[i]) top_valid[i] = 1'b0;
      foreach (mid_valid[i]) mid_valid[i] = 1'b0;
      foreach (leaf_valid[i]) leaf_valid[i] = 1'b0;
      mids_taken   = 0;
      leaves_taken = 0;
    endfunction

    // A written width is clamped into the supported range and empties the table.
    function void load_page_width(logic [PB_W-1:0] value);
      if (value < PB_MIN) begin
        page_width = PB_MIN;
      end else if (value > MAX_PAGE_BITS) begin
        page_width = MAX_PAGE_BITS;
      end else begin
        page_width = value;
      end
      empty_table();
    endfunction

    function int unsigned pending();
      return expected_walks.size();
    endfunction

    function void record_request(cmd_e cmd, logic [VPAGE_W-1:0] vp, logic [FRAME_W-1:0] frame);
      walk_result_t res;
      int unsigned  b1, b3, i1, i2, i3, mslot, lslot;
      bit           need_mid, need_leaf;
      res.hit    = 1'b0;
      res.frame  = '0;
      res.status = STATUS_OK;
      b1 = page_width / 3;
      b3 = page_width - 2 * b1;
      i1 = vp >> (b1 + b3);
      i2 = (vp >> b3) & ((1 << b1) - 1);
      i3 = vp & ((1 << b3) - 1);
      if (cmd != CMD_NOP && (vp >> page_width) != 0) begin
        res.status = STATUS_RANGE;
      end else if (cmd == CMD_INSERT) begin
        need_mid  = !top_valid[i1];
        need_leaf = need_mid || !mid_valid[top_block[i1] * MID_SLOTS + i2];
        if ((need_mid && mids_taken >= MID_BLOCKS) ||
            (need_leaf && leaves_taken >= LEAF_BLOCKS)) begin
          res.status = STATUS_EXHAUSTED;
        end else begin
          if (need_mid) begin
            top_block[i1] = mids_taken;
            top_valid[i1] = 1'b1;
            for (int s = 0; s < MID_SLOTS; s++) mid_valid[mids_taken * MID_SLOTS + s] = 1'b0;
            mids_taken++;
          end
          mslot = top_block[i1] * MID_SLOTS + i2;
          if (need_leaf) begin
            mid_block[mslot] = leaves_taken;
            mid_valid[mslot] = 1'b1;
            for (int s = 0; s < LEAF_SLOTS; s++) begin
              leaf_valid[leaves_taken * LEAF_SLOTS + s] = 1'b0;
            end
            leaves_taken++;
          end
          lslot = mid_block[mslot] * LEAF_SLOTS + i3;
          leaf_frame[lslot] = frame & FRAME_W'((1 << FRAME_BITS) - 1);
          leaf_valid[lslot] = 1'b1;
        end
      end else if ((cmd == CMD_LOOKUP || cmd == CMD_INVALIDATE) && top_valid[i1]) begin
        mslot = top_block[i1] * MID_SLOTS + i2;
        if (mid_valid[mslot]) begin
          lslot = mid_block[mslot] * LEAF_SLOTS + i3;
          if (cmd == CMD_INVALIDATE) begin
            leaf_valid[lslot] = 1'b0;
          end else if (leaf_valid[lslot]) begin
            res.hit   = 1'b1;
            res.frame = leaf_frame[lslot];
          end
        end
      end
      res.mid_used  = MID_USED_W'(mids_taken);
      res.leaf_used = LEAF_USED_W'(leaves_taken);
      expected_walks.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic hit, logic [FRAME_W-1:0] frame, logic [STATUS_W-1:0] status,
                               logic [MID_USED_W-1:0] mid_used,
                               logic [LEAF_USED_W-1:0] leaf_used);
      walk_result_t want;
      if (expected_walks.size() == 0) begin
        $error("result arrived with no item outstanding");
        mismatches++;
        return;
      end
      want = expected_walks.pop_front();
      compare_field("hit", want.hit, hit);
      compare_field("frame_out", want.frame, frame);
      compare_field("status", want.status, status);
      compare_field("second_level_used", want.mid_used, mid_used);
      compare_field("third_level_used", want.leaf_used, leaf_used);
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [PB_W-1:0]        cfg_wdata_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [CMD_W-1:0]       cmd_i;
  logic [VPAGE_W-1:0]     virtual_page_i;
  logic [FRAME_W-1:0]     frame_in_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic                   hit_o;
  logic [FRAME_W-1:0]     frame_out_o;
  logic [STATUS_W-1:0]    status_o;
  logic [MID_USED_W-1:0]  second_level_used_o;
  logic [LEAF_USED_W-1:0] third_level_used_o;

  page_walk_scoreboard sb = new();

  // Set during the last phases of the run: neither side inserts idle cycles then.
  bit          quiet = 1'b0;
  // A nonzero value asks the result side to hold off; the value sets how long.
  int unsigned hold_request = 0;
  // Up to 64 recent pages inserted this phase; lookups and invalidates use them.
  logic [VPAGE_W-1:0] mapped_pages [$];

  three_level_page_table u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .cmd_i               (cmd_i),
    .virtual_page_i      (virtual_page_i),
    .frame_in_i          (frame_in_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .hit_o               (hit_o),
    .frame_out_o         (frame_out_o),
    .status_o            (status_o),
    .second_level_used_o (second_level_used_o),
    .third_level_used_o  (third_level_used_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Every input starts at a known value; reset is held low until the stimulus
  // process releases it.
  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= '0;
    in_valid_i     <= 1'b0;
    cmd_i          <= CMD_LOOKUP;
    virtual_page_i <= '0;
    frame_in_i     <= '0;
    out_stall_i    <= 1'b0;
  end

  // Result side. Outputs are read right after the rising edge, so they still
  // hold the values that the edge sampled. A result is taken when valid was
  // high and stall low; then the stall for the next cycle is chosen. A hold-off
  // request from the stimulus turns into a long stall counted here.
  initial begin : result_side
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        sb.check_result(hit_o, frame_out_o, status_o, second_level_used_o, third_level_used_o);
      end
      if (hold_request != 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < 15) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offers one item and waits until it is accepted, then maybe idles for a burst.
  // Valid is only raised here and only lowered by an idle burst or a drain, so
  // it never gets two assignments in one step.
  task automatic issue(cmd_e cmd, logic [VPAGE_W-1:0] vp, logic [FRAME_W-1:0] frame);
    in_valid_i     <= 1'b1;
    cmd_i          <= cmd;
    virtual_page_i <= vp;
    frame_in_i     <= frame;
    do @(posedge clk_i); while (in_stall_o);
    sb.record_request(cmd, vp, frame);
    if (!quiet && $urandom_range(0, 99) < 15) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // The register is only written once the block has returned everything. Spare
  // cycles after the drain cover the last result leaving the output stage.
  task automatic write_page_width(logic [PB_W-1:0] value);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.load_page_width(value);
    mapped_pages.delete();
  endtask

  // Random items of one phase. Most pages are in range and lookups and
  // invalidates often reuse pages inserted before, so the walks reach the leaf
  // level; a few pages take all twelve bits and may fall outside the range.
  task automatic run_random(int unsigned count, bit with_hold_off, bit with_drain);
    int unsigned        pick;
    cmd_e               cmd;
    logic [VPAGE_W-1:0] vp;
    for (int unsigned n = 0; n < count; n++) begin
      if (with_hold_off && n == count / 3) begin
        hold_request = 80;
      end
      if (with_drain && n == count / 2) begin
        drain();
      end
      pick = $urandom_range(0, 99);
      if (pick < 42) begin
        cmd = CMD_INSERT;
      end else if (pick < 75) begin
        cmd = CMD_LOOKUP;
      end else if (pick < 95) begin
        cmd = CMD_INVALIDATE;
      end else begin
        cmd = CMD_NOP;
      end
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        vp = VPAGE_W'($urandom);
      end else if (pick < 60 && cmd != CMD_INSERT && mapped_pages.size() > 0) begin
        vp = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)];
      end else begin
        vp = VPAGE_W'($urandom) & VPAGE_W'((1 << sb.page_width) - 1);
      end
      if (cmd == CMD_INSERT) begin
        mapped_pages.push_back(vp);
        if (mapped_pages.size() > 64) void'(mapped_pages.pop_front());
      end
      issue(cmd, vp, FRAME_W'($urandom));
    end
  endtask

  initial begin : stimulus
    int unsigned phase_values [16] = '{15, 0, 12, 7, 4, 8, 11, 12, 5, 14, 9, 10, 6, 3, 1, 13};
    int unsigned count;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items at the reset width of twelve bits: an empty table, both
    // frame extremes, an overwrite, a neighbor in the same leaf block, an
    // invalidate of an absent path and no-ops.
    issue(CMD_LOOKUP, 12'd0, 16'h0000);
    issue(CMD_INVALIDATE, 12'd0, 16'h0000);
    issue(CMD_INSERT, 12'd0, 16'h0000);
    issue(CMD_LOOKUP, 12'd0, 16'hFFFF);
    issue(CMD_INSERT, 12'hFFF, 16'hFFFF);
    issue(CMD_LOOKUP, 12'hFFF, 16'h0000);
    issue(CMD_INSERT, 12'hFFF, 16'h1234);
    issue(CMD_LOOKUP, 12'hFFF, 16'h0000);
    issue(CMD_LOOKUP, 12'hFFE, 16'h0000);
    issue(CMD_INVALIDATE, 12'hFFF, 16'h0000);
    issue(CMD_LOOKUP, 12'hFFF, 16'h0000);
    issue(CMD_NOP, 12'hFFF, 16'hFFFF);
    issue(CMD_NOP, 12'd0, 16'h0000);

    // A written zero saturates to the smallest width: pages above seven are now
    // out of range for every command except the no-op.
    write_page_width(4'd0);
    issue(CMD_INSERT, 12'd7, 16'hA5A5);
    issue(CMD_LOOKUP, 12'd7, 16'h0000);
    issue(CMD_LOOKUP, 12'd6, 16'h0000);
    issue(CMD_INSERT, 12'd8, 16'h5A5A);
    issue(CMD_LOOKUP, 12'hFFF, 16'h0000);
    issue(CMD_INVALIDATE, 12'd8, 16'h0000);
    issue(CMD_NOP, 12'hFFF, 16'hFFFF);
    issue(CMD_INVALIDATE, 12'd7, 16'h0000);
    issue(CMD_LOOKUP, 12'd7, 16'h0000);

    // Random phases over many widths. Only the full width has more middle
    // slots than leaf blocks, so those phases are longer and run the leaf
    // pool dry. The last two phases run without idle cycles.
    foreach (phase_values[p]) begin
      write_page_width(PB_W'(phase_values[p]));
      if (p >= 14) quiet = 1'b1;
      count = (sb.page_width == MAX_PAGE_BITS) ? 250 : 60;
      run_random(count, p == 2, p == 4);
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/ptl_pkg.sv
rtl/ptl_ram.sv
rtl/three_level_page_table.sv
tb/sv/three_level_page_table_test.sv
